### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst, prop, msg)
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/orpc_pkg.sv
`default_nettype none
package orpc_pkg;

  localparam int MAX_CLUSTERS_DEF = 32;
  localparam int MAX_REPORT_DEF   = 8;

  localparam int CW   = 24;  // Q8.16 centroid
  localparam int PW   = 16;  // Q8.8 coordinate
  localparam int HW   = 16;  // hit count
  localparam int RADW = 15;
  localparam int RCW  = 4;
  localparam int CFGW = 16;
  localparam int RAMW = 2 * CW + HW;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  localparam logic [2:0] EV_MERGED  = 3'd0;
  localparam logic [2:0] EV_NEW     = 3'd1;
  localparam logic [2:0] EV_DROPPED = 3'd2;
  localparam logic [2:0] EV_CLEARED = 3'd3;
  localparam logic [2:0] EV_ENTRY   = 3'd4;
  localparam logic [2:0] EV_EMPTY   = 3'd5;

  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_MIN_HITS     = 2'd1;
  localparam logic [1:0] REG_REPORT_COUNT = 2'd2;

  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_MERGE = 2'd1;
  localparam logic [1:0] SEL_NEW   = 2'd2;
  localparam logic [1:0] SEL_PEND  = 2'd3;

  localparam logic [RADW-1:0] RADIUS_RST = 15'd128;
  localparam logic [HW-1:0]   MIN_HITS_RST = 16'd5;
  localparam logic [RCW-1:0]  REPORT_COUNT_RST = 4'd4;
  localparam logic [HW-1:0]   HITS_MAX = 16'hFFFF;

  // divide by 100: floor(v * RECIP >> 32), off by at most one
  localparam logic [25:0] RECIP      = 26'd42949672;
  localparam int          RECIP_SH   = 32;
  localparam logic [6:0]  BLEND_DIV  = 7'd100;
  localparam logic [5:0]  BLEND_BIAS = 6'd50;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_add;
    logic       scan_rep;
    logic       rep_init;
    logic       take;
    logic       wr_merge;
    logic       wr_new;
    logic       clear;
    logic       emit;
    logic [1:0] emit_sel;
    logic [2:0] ev;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic match;
    logic full;
    logic best_v;
    logic pend_v;
    logic last_take;
    logic limit_zero;
  } stat_t;

  // Q8.16 -> Q8.8, round half up, saturate at the top
  function automatic logic signed [PW-1:0] to_q88(input logic signed [CW-1:0] c);
    logic signed [CW:0] s;
    s = {c[CW-1], c} + 25'sd128;
    if (!s[CW] && s[CW-1]) to_q88 = 16'sh7FFF;
    else to_q88 = s[CW-1:8];
  endfunction

endpackage
`default_nettype wire

### rtl/online_radius_point_clusterer_top.sv
`default_nettype none
// Leader clusterer over a table of up to MAX_CLUSTERS 2-D centroids held in one
// block RAM. An item is taken when start is high and busy is low; results come
// out one per cycle-wide strobe and cannot be held off, so the receiver must
// take each one as it appears. An add reads the table one entry per cycle
// through a three-stage distance pipeline and stops at the first hit; a merge
// then runs the divide-by-100 blend and writes the entry back. A clear completes
// without leaving idle. A report repeats a full table pass for each reported
// entry, plus one more pass that finds none unless report_count is reached.
// Configuration must be written through cfg_write/cfg_index/cfg_data only while
// idle; the block does not enforce this.
module online_radius_point_clusterer_top #(
  parameter int MAX_CLUSTERS = orpc_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_REPORT   = orpc_pkg::MAX_REPORT_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire [1:0]                          action,
  input  wire signed [orpc_pkg::PW-1:0]      point_x,
  input  wire signed [orpc_pkg::PW-1:0]      point_y,
  input  wire                                cfg_write,
  input  wire [1:0]                          cfg_index,
  input  wire [orpc_pkg::CFGW-1:0]           cfg_data,
  output logic                               strobe,
  output logic [2:0]                         event_res,
  output logic [$clog2(MAX_CLUSTERS)-1:0]    cluster_index,
  output logic signed [orpc_pkg::PW-1:0]     cluster_x,
  output logic signed [orpc_pkg::PW-1:0]     cluster_y,
  output logic [orpc_pkg::HW-1:0]            cluster_hits,
  output logic                               last
);
  orpc_pkg::cmd_t  cmd;
  orpc_pkg::stat_t stat;

  orpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  orpc_datapath #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_REPORT(MAX_REPORT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_x(point_x), .point_y(point_y),
    .strobe(strobe), .event_res(event_res), .cluster_index(cluster_index),
    .cluster_x(cluster_x), .cluster_y(cluster_y), .cluster_hits(cluster_hits),
    .last(last)
  );
endmodule
`default_nettype wire

### rtl/orpc_ram.sv
`default_nettype none
module orpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/orpc_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module orpc_datapath #(
  parameter int MAX_CLUSTERS = orpc_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_REPORT   = orpc_pkg::MAX_REPORT_DEF,
  parameter int IDX_W        = $clog2(MAX_CLUSTERS)
) (
  input  wire                             clk,
  input  wire                             rst,
  input  orpc_pkg::cmd_t                  cmd,
  output orpc_pkg::stat_t                 stat,
  input  wire                             cfg_write,
  input  wire [1:0]                       cfg_index,
  input  wire [orpc_pkg::CFGW-1:0]        cfg_data,
  input  wire signed [orpc_pkg::PW-1:0]   point_x,
  input  wire signed [orpc_pkg::PW-1:0]   point_y,
  output logic                            strobe,
  output logic [2:0]                      event_res,
  output logic [IDX_W-1:0]                cluster_index,
  output logic signed [orpc_pkg::PW-1:0]  cluster_x,
  output logic signed [orpc_pkg::PW-1:0]  cluster_y,
  output logic [orpc_pkg::HW-1:0]         cluster_hits,
  output logic                            last
);
  localparam int CW    = orpc_pkg::CW;
  localparam int HW    = orpc_pkg::HW;
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int LIM_W = $clog2(MAX_REPORT + 1);
  localparam int RECIP_HI = orpc_pkg::RECIP_SH + 18;

  logic [orpc_pkg::RADW-1:0] match_radius;
  logic [HW-1:0]             min_hits;
  logic [orpc_pkg::RCW-1:0]  report_count;
  logic [2*orpc_pkg::RADW-1:0] rad2;

  logic signed [CW-1:0] px, py;
  logic [CNT_W-1:0] used, addr;
  logic issue;

  logic [orpc_pkg::RAMW-1:0] rdata, wdata;
  logic [IDX_W-1:0] waddr;
  logic we;
  logic signed [CW-1:0] rd_x, rd_y;
  logic [HW-1:0] rd_h;

  logic s1_v, s2_v;
  logic [IDX_W-1:0] s1_idx, s2_idx;
  logic signed [CW-1:0] s2_x, s2_y;
  logic [HW-1:0] s2_h;
  logic [48:0] s2_sqx, s2_sqy;
  logic signed [CW:0] dx, dy;
  logic signed [2*CW+1:0] sqx, sqy;
  logic [49:0] d2;

  logic m_v;
  logic [IDX_W-1:0] m_idx;
  logic signed [CW-1:0] m_x, m_y;
  logic [HW-1:0] m_h, h_sat;

  logic [MAX_CLUSTERS-1:0] taken;
  logic best_v, pend_v;
  logic [IDX_W-1:0] best_idx, pend_idx;
  logic signed [CW-1:0] best_x, best_y, pend_x, pend_y;
  logic [HW-1:0] best_h, pend_h;
  logic [LIM_W-1:0] n, limit;

  // blend pipeline
  logic signed [CW:0] bdx, bdy;
  logic b_negx, b_negy, c_negx, c_negy;
  logic [CW:0] b_vx, b_vy, c_vx, c_vy;
  logic [50:0] c_px, c_py;
  logic [18:0] qex, qey, qx, qy;
  logic [CW+1:0] remx, remy;
  logic signed [CW-1:0] nx, ny;
  logic signed [CW:0] nx_w, ny_w;

  orpc_ram #(.WIDTH(orpc_pkg::RAMW), .DEPTH(MAX_CLUSTERS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(addr[IDX_W-1:0]), .rdata(rdata)
  );

  assign rd_x = rdata[orpc_pkg::RAMW-1 -: CW];
  assign rd_y = rdata[HW +: CW];
  assign rd_h = rdata[HW-1:0];

  assign issue = (cmd.scan_add || cmd.scan_rep) && (addr < used) && !m_v;
  assign h_sat = (m_h == orpc_pkg::HITS_MAX) ? m_h : m_h + 16'd1;

  always_comb begin
    limit = (int'(report_count) < MAX_REPORT) ? LIM_W'(report_count) : LIM_W'(MAX_REPORT);
    dx  = {rd_x[CW-1], rd_x} - {px[CW-1], px};
    dy  = {rd_y[CW-1], rd_y} - {py[CW-1], py};
    sqx = dx * dx;
    sqy = dy * dy;
    d2  = {1'b0, s2_sqx} + {1'b0, s2_sqy};
    we    = cmd.wr_merge || cmd.wr_new;
    waddr = cmd.wr_merge ? m_idx : used[IDX_W-1:0];
    wdata = cmd.wr_merge ? {nx, ny, h_sat} : {px, py, 16'd1};
    stat.scan_done  = m_v || ((addr >= used) && !s1_v && !s2_v);
    stat.match      = m_v;
    stat.full       = (used == CNT_W'(MAX_CLUSTERS));
    stat.best_v     = best_v;
    stat.pend_v     = pend_v;
    stat.last_take  = ((n + LIM_W'(1)) == limit);
    stat.limit_zero = (limit == '0);
    // blend: q = (|d| + 50) / 100, corrected reciprocal
    bdx  = {px[CW-1], px} - {m_x[CW-1], m_x};
    bdy  = {py[CW-1], py} - {m_y[CW-1], m_y};
    qex  = c_px[RECIP_HI:orpc_pkg::RECIP_SH];
    qey  = c_py[RECIP_HI:orpc_pkg::RECIP_SH];
    remx = {1'b0, c_vx} - (CW+2)'(qex) * (CW+2)'(orpc_pkg::BLEND_DIV);
    remy = {1'b0, c_vy} - (CW+2)'(qey) * (CW+2)'(orpc_pkg::BLEND_DIV);
    qx   = qex + ((remx >= (CW+2)'(orpc_pkg::BLEND_DIV)) ? 19'd1 : 19'd0);
    qy   = qey + ((remy >= (CW+2)'(orpc_pkg::BLEND_DIV)) ? 19'd1 : 19'd0);
    nx_w = c_negx ? {m_x[CW-1], m_x} - (CW+1)'(qx) : {m_x[CW-1], m_x} + (CW+1)'(qx);
    ny_w = c_negy ? {m_y[CW-1], m_y} - (CW+1)'(qy) : {m_y[CW-1], m_y} + (CW+1)'(qy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_radius <= orpc_pkg::RADIUS_RST;
      min_hits     <= orpc_pkg::MIN_HITS_RST;
      report_count <= orpc_pkg::REPORT_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        orpc_pkg::REG_RADIUS:       match_radius <= cfg_data[orpc_pkg::RADW-1:0];
        orpc_pkg::REG_MIN_HITS:     min_hits     <= cfg_data[HW-1:0];
        orpc_pkg::REG_REPORT_COUNT: report_count <= cfg_data[orpc_pkg::RCW-1:0];
        default: ;
      endcase
    end
  end

  // scan control and table occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0; addr <= '0; s1_v <= 1'b0; s2_v <= 1'b0;
      m_v <= 1'b0; best_v <= 1'b0; pend_v <= 1'b0; taken <= '0; n <= '0;
      strobe <= 1'b0;
    end else begin
      if (cmd.clear) used <= '0;
      else if (cmd.wr_new) used <= used + CNT_W'(1);
      if (cmd.scan_start) begin
        addr <= '0; s1_v <= 1'b0; s2_v <= 1'b0; m_v <= 1'b0; best_v <= 1'b0;
      end else begin
        if (issue) addr <= addr + CNT_W'(1);
        s1_v <= issue;
        s2_v <= s1_v;
        if (cmd.scan_add && s2_v && !m_v && (d2 < {4'd0, rad2, 16'd0})) m_v <= 1'b1;
        if (cmd.scan_rep && s1_v && !taken[s1_idx] && (rd_h >= min_hits) &&
            (!best_v || (rd_h > best_h))) best_v <= 1'b1;
      end
      if (cmd.rep_init) begin
        taken <= '0; n <= '0; pend_v <= 1'b0;
      end else if (cmd.take) begin
        taken[best_idx] <= 1'b1;
        n <= n + LIM_W'(1);
        pend_v <= 1'b1;
      end
      strobe <= cmd.emit;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rad2 <= match_radius * match_radius;
    if (cmd.load) begin
      px <= {point_x, 8'd0};
      py <= {point_y, 8'd0};
    end
    s1_idx <= addr[IDX_W-1:0];
    s2_idx <= s1_idx;
    s2_x <= rd_x; s2_y <= rd_y; s2_h <= rd_h;
    s2_sqx <= sqx[48:0];
    s2_sqy <= sqy[48:0];
    if (cmd.scan_add && s2_v && !m_v) begin
      m_idx <= s2_idx; m_x <= s2_x; m_y <= s2_y; m_h <= s2_h;
    end
    if (cmd.scan_rep && s1_v && !taken[s1_idx] && (rd_h >= min_hits) &&
        (!best_v || (rd_h > best_h))) begin
      best_idx <= s1_idx; best_x <= rd_x; best_y <= rd_y; best_h <= rd_h;
    end
    if (cmd.take) begin
      pend_idx <= best_idx; pend_x <= best_x; pend_y <= best_y; pend_h <= best_h;
    end
    b_negx <= bdx[CW];
    b_negy <= bdy[CW];
    b_vx <= (bdx[CW] ? -bdx : bdx) + (CW+1)'(orpc_pkg::BLEND_BIAS);
    b_vy <= (bdy[CW] ? -bdy : bdy) + (CW+1)'(orpc_pkg::BLEND_BIAS);
    c_negx <= b_negx; c_negy <= b_negy;
    c_vx <= b_vx; c_vy <= b_vy;
    c_px <= b_vx * orpc_pkg::RECIP;
    c_py <= b_vy * orpc_pkg::RECIP;
    nx <= nx_w[CW-1:0];
    ny <= ny_w[CW-1:0];
    if (cmd.emit) begin
      event_res <= cmd.ev;
      last      <= cmd.last;
      case (cmd.emit_sel)
        orpc_pkg::SEL_MERGE: begin
          cluster_index <= m_idx;
          cluster_x <= orpc_pkg::to_q88(nx); cluster_y <= orpc_pkg::to_q88(ny);
          cluster_hits <= h_sat;
        end
        orpc_pkg::SEL_NEW: begin
          cluster_index <= used[IDX_W-1:0];
          cluster_x <= orpc_pkg::to_q88(px); cluster_y <= orpc_pkg::to_q88(py);
          cluster_hits <= 16'd1;
        end
        orpc_pkg::SEL_PEND: begin
          cluster_index <= pend_idx;
          cluster_x <= orpc_pkg::to_q88(pend_x); cluster_y <= orpc_pkg::to_q88(pend_y);
          cluster_hits <= pend_h;
        end
        default: begin
          cluster_index <= '0; cluster_x <= '0; cluster_y <= '0; cluster_hits <= '0;
        end
      endcase
    end
  end

  `ASSERT_CHK(a_used_range, clk, rst, used <= CNT_W'(MAX_CLUSTERS), "table count overflow")
  `ASSERT_IMP(a_s2_follows, clk, rst, s2_v, $past(s1_v), "scan stage out of order")
  `ASSERT_IMP(a_no_new_full, clk, rst, cmd.wr_new, used < CNT_W'(MAX_CLUSTERS), "append when full")

endmodule
`default_nettype wire

### rtl/orpc_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module orpc_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire [1:0]        action,
  input  orpc_pkg::stat_t  stat,
  output logic             busy,
  output orpc_pkg::cmd_t   cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ASCAN = 4'd1;
  localparam logic [3:0] S_B1    = 4'd2;
  localparam logic [3:0] S_B2    = 4'd3;
  localparam logic [3:0] S_B3    = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_RSCAN = 4'd6;
  localparam logic [3:0] S_RDONE = 4'd7;
  localparam logic [3:0] S_RFIN  = 4'd8;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit_sel = orpc_pkg::SEL_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (action)
            orpc_pkg::ACT_ADD: begin
              cmd.scan_start = 1'b1;
              state_next = S_ASCAN;
            end
            orpc_pkg::ACT_CLEAR: begin
              cmd.clear = 1'b1;
              cmd.emit = 1'b1; cmd.ev = orpc_pkg::EV_CLEARED; cmd.last = 1'b1;
            end
            orpc_pkg::ACT_REPORT: begin
              if (stat.limit_zero) begin
                cmd.emit = 1'b1; cmd.ev = orpc_pkg::EV_EMPTY; cmd.last = 1'b1;
              end else begin
                cmd.rep_init = 1'b1;
                cmd.scan_start = 1'b1;
                state_next = S_RSCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_ASCAN: begin
        cmd.scan_add = 1'b1;
        if (stat.scan_done) begin
          if (stat.match) begin
            state_next = S_B1;
          end else if (stat.full) begin
            cmd.emit = 1'b1; cmd.ev = orpc_pkg::EV_DROPPED; cmd.last = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.wr_new = 1'b1;
            cmd.emit = 1'b1; cmd.emit_sel = orpc_pkg::SEL_NEW;
            cmd.ev = orpc_pkg::EV_NEW; cmd.last = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_B1: state_next = S_B2;
      S_B2: state_next = S_B3;
      S_B3: state_next = S_WR;
      S_WR: begin
        cmd.wr_merge = 1'b1;
        cmd.emit = 1'b1; cmd.emit_sel = orpc_pkg::SEL_MERGE;
        cmd.ev = orpc_pkg::EV_MERGED; cmd.last = 1'b1;
        state_next = S_IDLE;
      end
      S_RSCAN: begin
        cmd.scan_rep = 1'b1;
        if (stat.scan_done) state_next = S_RDONE;
      end
      S_RDONE: begin
        cmd.ev = orpc_pkg::EV_ENTRY;
        if (stat.best_v) begin
          // previous pick goes out now that another one follows it
          cmd.emit = stat.pend_v;
          cmd.emit_sel = orpc_pkg::SEL_PEND;
          cmd.take = 1'b1;
          if (stat.last_take) begin
            state_next = S_RFIN;
          end else begin
            cmd.scan_start = 1'b1;
            state_next = S_RSCAN;
          end
        end else begin
          cmd.emit = 1'b1; cmd.last = 1'b1;
          if (stat.pend_v) cmd.emit_sel = orpc_pkg::SEL_PEND;
          else cmd.ev = orpc_pkg::EV_EMPTY;
          state_next = S_IDLE;
        end
      end
      S_RFIN: begin
        cmd.emit = 1'b1; cmd.emit_sel = orpc_pkg::SEL_PEND;
        cmd.ev = orpc_pkg::EV_ENTRY; cmd.last = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_IMP(a_idle_quiet, clk, rst, state == S_IDLE, !cmd.scan_add && !cmd.scan_rep, "scan in idle")
  `ASSERT_IMP(a_last_ends, clk, rst, cmd.emit && cmd.last, state_next == S_IDLE, "last but busy")
  `ASSERT_IMP(a_blend_entry, clk, rst, state == S_B1, $past(state) == S_ASCAN, "blend without scan")

endmodule
`default_nettype wire
